[rtl/sist_pkg.sv]
package sist_pkg;

  // Table geometry
  localparam int CAPACITY = 256;
  localparam int POS_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 64;

  // Request kinds (the unused code behaves as a search)
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_DEL    = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // Width classes
  localparam logic [1:0] ENC_16 = 2'd0;
  localparam logic [1:0] ENC_32 = 2'd1;
  localparam logic [1:0] ENC_64 = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t           op;
    logic [VAL_W-1:0]   value;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_ENC,
    ST_UPD
  } state_t;

endpackage

[rtl/sist_req_if.sv]
interface sist_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic signed [sist_pkg::VAL_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

[rtl/sist_res_if.sv]
interface sist_res_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [sist_pkg::POS_W-1:0]      position;
  logic [sist_pkg::POS_W-1:0]      count;
  logic [1:0]                      encoding;

  modport source (output valid, output status, output position, output count,
                  output encoding, input ready);
  modport sink   (input valid, input status, input position, input count,
                  input encoding, output ready);
endinterface

[rtl/sist_cell.sv]
// One slot of the sorted chain: holds an entry, its compare flags,
// and shifts up or down from its neighbours.
module sist_cell (
  input  logic                          clk,
  input  sist_pkg::cell_ctl_t           ctl,
  input  logic                          occ,
  input  logic [sist_pkg::VAL_W-1:0]    left_entry,
  input  logic                          left_lt,
  input  logic [sist_pkg::VAL_W-1:0]    right_entry,
  output logic [sist_pkg::VAL_W-1:0]    entry,
  output logic                          lt,
  output logic                          eq
);

  logic [sist_pkg::VAL_W-1:0] entry_r;
  logic                       lt_r;
  logic                       eq_r;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      sist_pkg::CELL_CMP: begin
        lt_r <= occ & ($signed(entry_r) < $signed(ctl.value));
        eq_r <= occ & (entry_r == ctl.value);
      end
      sist_pkg::CELL_INS: begin
        // first slot not below the value takes it, the rest move up
        if (!lt_r) begin
          entry_r <= left_lt ? ctl.value : left_entry;
        end
      end
      sist_pkg::CELL_DEL: begin
        if (!lt_r) begin
          entry_r <= right_entry;
        end
      end
      sist_pkg::CELL_HOLD: begin
      end
    endcase
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

[rtl/sist_pos_enc.sv]
// Turns the chain's less-than thermometer into an index, registered.
module sist_pos_enc (
  input  logic                          clk,
  input  logic [sist_pkg::CAPACITY-1:0] lt,
  input  logic [sist_pkg::CAPACITY-1:0] eq,
  output logic [sist_pkg::POS_W-1:0]    pos,
  output logic                          found
);

  logic [sist_pkg::CAPACITY+1:0] lt_ext;
  logic [sist_pkg::POS_W-1:0]    pos_nxt;
  logic [sist_pkg::POS_W-1:0]    pos_r;
  logic                          found_r;

  // bit 0 stands for "below slot 0", top bit for "past the end"
  assign lt_ext = {1'b0, lt, 1'b1};

  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i <= sist_pkg::CAPACITY; i++) begin
      if (lt_ext[i] && !lt_ext[i+1]) begin
        pos_nxt = pos_nxt | sist_pkg::POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    found_r <= |eq;
  end

  assign pos   = pos_r;
  assign found = found_r;

endmodule

[rtl/sorted_integer_set_table.sv]
// Sorted integer set table.
// Holds up to CAPACITY signed 64-bit values in strictly ascending order and
// serves one request at a time on in_req: add, delete or search.
// Each request gives exactly one result on out_res: status, position (index
// or insertion point), entry count after the request and width class.
// Built as a chain of cells, one per slot: every cell compares its entry with
// the request value in parallel, a registered encoder turns the compare flags
// into a position, then the cells from that position upward shift by one slot
// together to insert or delete. A request is taken in the idle step; its result
// goes into the output register after the compare, encode and update steps.
// No new request is taken until the block has gone through this
// compare-encode-update sequence and is back in the idle step.
// A finished result sits in the output register; the next request is
// accepted meanwhile. If the receiver stalls and the register is still full
// when the next result is ready, the block holds in its update step.
// Reset (rst_n low, synchronous) empties the table and sets the width class
// to 16-bit; slot contents are not cleared and are never read while unused.
module sorted_integer_set_table (
  input  logic              clk,
  input  logic              rst_n,
  sist_req_if.sink          in_req,
  sist_res_if.source        out_res
);

  localparam int N = sist_pkg::CAPACITY;
  localparam int W = sist_pkg::POS_W;

  sist_pkg::state_t          state_r, state_nxt;
  logic [1:0]                kind_r;
  logic [sist_pkg::VAL_W-1:0] value_r;
  logic [W-1:0]              count_r, count_nxt;
  logic [1:0]                wclass_r, wclass_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                status_r, status_nxt;
  logic [W-1:0]              position_r;
  logic [W-1:0]              count_out_r;
  logic [1:0]                enc_out_r;
  logic                      load_out;

  sist_pkg::cell_ctl_t       ctl;
  logic [N-1:0]              occ;
  logic [sist_pkg::VAL_W-1:0] entry_w [N];
  logic [N-1:0]              lt_w;
  logic [N-1:0]              eq_w;
  logic [W-1:0]              pos;
  logic                      found;

  logic                      is_add, is_del, full;
  logic [1:0]                need;

  // occupancy thermometer from the count
  for (genvar g = 0; g < N; g++) begin : g_occ
    assign occ[g] = (W'(g) < count_r);
  end

  // the chain
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [sist_pkg::VAL_W-1:0] left_e, right_e;
    logic                       left_l;
    if (g == 0) begin : g_first
      assign left_e = '0;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = entry_w[g-1];
      assign left_l = lt_w[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entry_w[g+1];
    end
    sist_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ[g]),
      .left_entry  (left_e),
      .left_lt     (left_l),
      .right_entry (right_e),
      .entry       (entry_w[g]),
      .lt          (lt_w[g]),
      .eq          (eq_w[g])
    );
  end

  sist_pos_enc u_enc (
    .clk   (clk),
    .lt    (lt_w),
    .eq    (eq_w),
    .pos   (pos),
    .found (found)
  );

  assign is_add = (kind_r == sist_pkg::KIND_ADD);
  assign is_del = (kind_r == sist_pkg::KIND_DEL);
  assign full   = (count_r == W'(N));

  // width class the value needs: upper bits all sign copies or not
  always_comb begin
    if (!((&value_r[63:31]) || !(|value_r[63:31]))) begin
      need = sist_pkg::ENC_64;
    end else if (!((&value_r[63:15]) || !(|value_r[63:15]))) begin
      need = sist_pkg::ENC_32;
    end else begin
      need = sist_pkg::ENC_16;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctl.op        = sist_pkg::CELL_HOLD;
    ctl.value     = value_r;
    count_nxt     = count_r;
    wclass_nxt    = wclass_r;
    status_nxt    = found ? sist_pkg::STAT_OK : sist_pkg::STAT_MISS;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_res.ready;

    unique case (state_r)
      sist_pkg::ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = sist_pkg::ST_CMP;
        end
      end
      sist_pkg::ST_CMP: begin
        ctl.op    = sist_pkg::CELL_CMP;
        state_nxt = sist_pkg::ST_ENC;
      end
      sist_pkg::ST_ENC: begin
        state_nxt = sist_pkg::ST_UPD;
      end
      sist_pkg::ST_UPD: begin
        if (is_add) begin
          if (found) begin
            status_nxt = sist_pkg::STAT_MISS;
          end else if (full) begin
            status_nxt = sist_pkg::STAT_FULL;
          end else begin
            status_nxt = sist_pkg::STAT_OK;
          end
        end
        // wait here while the result register is still occupied
        if (!out_valid_r || out_res.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sist_pkg::ST_IDLE;
          if (is_add && !found && !full) begin
            ctl.op    = sist_pkg::CELL_INS;
            count_nxt = count_r + W'(1);
            if (need > wclass_r) begin
              wclass_nxt = need;
            end
          end else if (is_del && found) begin
            ctl.op    = sist_pkg::CELL_DEL;
            count_nxt = count_r - W'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sist_pkg::ST_IDLE;
      count_r     <= '0;
      wclass_r    <= sist_pkg::ENC_16;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wclass_r    <= wclass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      kind_r  <= in_req.kind;
      value_r <= in_req.value;
    end
    if (load_out) begin
      status_r    <= status_nxt;
      position_r  <= pos;
      count_out_r <= count_nxt;
      enc_out_r   <= wclass_nxt;
    end
  end

  assign in_req.ready     = (state_r == sist_pkg::ST_IDLE);
  assign out_res.valid    = out_valid_r;
  assign out_res.status   = status_r;
  assign out_res.position = position_r;
  assign out_res.count    = count_out_r;
  assign out_res.encoding = enc_out_r;

endmodule

[tb/tb_sorted_integer_set_table.sv]
`timescale 1ns / 100ps

// Self-checking bench for the sorted integer set table.
// A short table of directed requests opens the run, then three random phases
// with different idling on each side. Every accepted request is fed to a
// behavioural copy of the set, whose result is queued and compared with
// what comes out of the block, in order.
module tb_sorted_integer_set_table;

  localparam int          CLK_HALF    = 6;       // 12 ns period
  localparam int          RESET_LEN   = 7;
  localparam int          LONG_HOLD   = 80;      // receiver hold-off, in cycles
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          N_DIRECTED  = 25;
  localparam int          N_MIXED     = 90;
  localparam int          N_AT_FULL   = 20;
  localparam int          N_DRAIN     = 100;
  localparam int          MAX_REPORTS = 10;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;    // decodes as a search

  localparam longint INT64_MIN = 64'sh8000_0000_0000_0000;
  localparam longint INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]                status;
    logic [sist_pkg::POS_W-1:0] position;
    logic [sist_pkg::POS_W-1:0] count;
    logic [1:0]                encoding;
  } table_result_t;

  // One row of the directed table. Rows with fixed set carry a hand-written
  // result; the rest take whatever the behavioural set gives.
  typedef struct packed {
    logic [1:0]        kind;
    logic signed [63:0] value;
    logic              fixed;
    table_result_t     result;
  } directed_row_t;

  logic clk;
  logic rst_n;

  sist_req_if req_ch ();
  sist_res_if res_ch ();

  sorted_integer_set_table i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  // Behavioural copy of the table
  longint     set_vals [sist_pkg::CAPACITY];
  int         set_count;
  logic [1:0] set_class;

  table_result_t pending_results [$];

  int  sender_idle_pct;
  int  receiver_idle_pct;
  bit  long_hold;
  int  cycle_count;
  int  mismatch_count;
  int  requests_sent;
  int  results_seen;
  int  full_refusals;
  int  peak_count;

  directed_row_t directed_rows [N_DIRECTED];

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Width class a value needs on its own
  function automatic logic [1:0] class_for(longint v);
    if (v < -64'sd2147483648 || v > 64'sd2147483647) return sist_pkg::ENC_64;
    if (v < -64'sd32768 || v > 64'sd32767) return sist_pkg::ENC_32;
    return sist_pkg::ENC_16;
  endfunction

  // Applies one request to the behavioural set and returns its result
  function automatic table_result_t predict_request(logic [1:0] kind, longint v);
    table_result_t res;
    int            pos;
    bit            found;
    logic [1:0]    need;
    pos = 0;
    while (pos < set_count && set_vals[pos] < v) pos++;
    found = (pos < set_count) && (set_vals[pos] == v);
    res.status = found ? sist_pkg::STAT_OK : sist_pkg::STAT_MISS;
    if (kind == sist_pkg::KIND_ADD) begin
      if (found) begin
        res.status = sist_pkg::STAT_MISS;
      end else if (set_count >= sist_pkg::CAPACITY) begin
        res.status = sist_pkg::STAT_FULL;
      end else begin
        for (int i = set_count; i > pos; i--) set_vals[i] = set_vals[i-1];
        set_vals[pos] = v;
        set_count++;
        need = class_for(v);
        if (need > set_class) set_class = need;
        res.status = sist_pkg::STAT_OK;
      end
    end else if (kind == sist_pkg::KIND_DEL) begin
      if (found) begin
        for (int i = pos; i < set_count - 1; i++) set_vals[i] = set_vals[i+1];
        set_count--;
      end
    end
    res.position = pos[sist_pkg::POS_W-1:0];
    res.count    = set_count[sist_pkg::POS_W-1:0];
    res.encoding = set_class;
    return res;
  endfunction

  // Random value: small numbers for collisions, stored values and their
  // neighbours for hits, class edges, and full 64-bit noise
  function automatic longint pick_value();
    longint edges [10];
    edges = '{-64'sd32769, -64'sd32768, 64'sd32767, 64'sd32768,
              -64'sd2147483649, -64'sd2147483648, 64'sd2147483647,
              64'sd2147483648, INT64_MIN, INT64_MAX};
    case ($urandom_range(0, 9))
      0, 1, 2: return longint'($urandom_range(0, 80)) - 40;
      3, 4: begin
        if (set_count == 0) return longint'($urandom_range(0, 80)) - 40;
        return set_vals[$urandom_range(0, set_count - 1)]
               + longint'($urandom_range(0, 2)) - 1;
      end
      5: return edges[$urandom_range(0, 9)];
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one request; caller and callee both sit at a falling edge.
  // Gaps before the request follow sender_idle_pct.
  task automatic send_request(logic [1:0] kind, longint v, bit fixed,
                              table_result_t fixed_res);
    table_result_t res;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // request taken at this edge
    res = predict_request(kind, v);
    if (res.status == sist_pkg::STAT_FULL) full_refusals++;
    if (set_count > peak_count) peak_count = set_count;
    pending_results.push_back(fixed ? fixed_res : res);
    requests_sent++;
    @(negedge clk);
  endtask

  // Sender stands still until the block has handed back every result
  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [1:0] random_kind(int add_w, int del_w, int srch_w);
    int r;
    r = $urandom_range(0, add_w + del_w + srch_w);
    if (r < add_w) return sist_pkg::KIND_ADD;
    if (r < add_w + del_w) return sist_pkg::KIND_DEL;
    if (r < add_w + del_w + srch_w) return sist_pkg::KIND_SEARCH;
    return KIND_UNUSED;
  endfunction

  // Receiver: ready changes on the falling edge; a long hold-off is counted
  // here so the sender can keep pushing meanwhile
  initial begin
    int held;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          res_ch.ready <= 1'b0;
          @(negedge clk);
          held++;
        end
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        @(negedge clk);
      end
    end
  end

  // Result checker: oldest expectation against each result taken
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("tb: unexpected result st=%0d pos=%0d cnt=%0d enc=%0d",
                   res_ch.status, res_ch.position, res_ch.count, res_ch.encoding);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.status !== want.status || res_ch.position !== want.position ||
            res_ch.count !== want.count || res_ch.encoding !== want.encoding) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"tb: result %0d exp st=%0d pos=%0d cnt=%0d enc=%0d, ",
                      "got st=%0d pos=%0d cnt=%0d enc=%0d"},
                     results_seen, want.status, want.position, want.count,
                     want.encoding, res_ch.status, res_ch.position, res_ch.count,
                     res_ch.encoding);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: timeout after %0d cycles", cycle_count);
    $display("tb: failure");
    $finish;
  end

  initial begin
    directed_row_t row;
    table_result_t none;
    // Empty table, kind decode, class edges in both directions, both 64-bit
    // extremes, duplicate add, absent delete, class staying wide after the
    // 64-bit extremes leave. The tail rows are checked by the behavioural set.
    directed_rows = '{
      '{sist_pkg::KIND_SEARCH, 64'sd0, 1'b1,
        '{sist_pkg::STAT_MISS, 9'd0, 9'd0, sist_pkg::ENC_16}},
      '{sist_pkg::KIND_DEL, 64'sd5, 1'b1,
        '{sist_pkg::STAT_MISS, 9'd0, 9'd0, sist_pkg::ENC_16}},
      '{KIND_UNUSED, 64'sd0, 1'b1,
        '{sist_pkg::STAT_MISS, 9'd0, 9'd0, sist_pkg::ENC_16}},
      '{sist_pkg::KIND_ADD, 64'sd0, 1'b1,
        '{sist_pkg::STAT_OK, 9'd0, 9'd1, sist_pkg::ENC_16}},
      '{sist_pkg::KIND_ADD, 64'sd0, 1'b1,
        '{sist_pkg::STAT_MISS, 9'd0, 9'd1, sist_pkg::ENC_16}},
      '{sist_pkg::KIND_ADD, 64'sd32767, 1'b1,
        '{sist_pkg::STAT_OK, 9'd1, 9'd2, sist_pkg::ENC_16}},
      '{sist_pkg::KIND_ADD, -64'sd32768, 1'b1,
        '{sist_pkg::STAT_OK, 9'd0, 9'd3, sist_pkg::ENC_16}},
      '{sist_pkg::KIND_ADD, 64'sd32768, 1'b1,
        '{sist_pkg::STAT_OK, 9'd3, 9'd4, sist_pkg::ENC_32}},
      '{sist_pkg::KIND_ADD, -64'sd2147483648, 1'b1,
        '{sist_pkg::STAT_OK, 9'd0, 9'd5, sist_pkg::ENC_32}},
      '{sist_pkg::KIND_ADD, 64'sd2147483647, 1'b1,
        '{sist_pkg::STAT_OK, 9'd5, 9'd6, sist_pkg::ENC_32}},
      '{sist_pkg::KIND_ADD, 64'sd2147483648, 1'b1,
        '{sist_pkg::STAT_OK, 9'd6, 9'd7, sist_pkg::ENC_64}},
      '{sist_pkg::KIND_ADD, INT64_MIN, 1'b1,
        '{sist_pkg::STAT_OK, 9'd0, 9'd8, sist_pkg::ENC_64}},
      '{sist_pkg::KIND_ADD, INT64_MAX, 1'b1,
        '{sist_pkg::STAT_OK, 9'd8, 9'd9, sist_pkg::ENC_64}},
      '{sist_pkg::KIND_SEARCH, INT64_MAX, 1'b1,
        '{sist_pkg::STAT_OK, 9'd8, 9'd9, sist_pkg::ENC_64}},
      '{sist_pkg::KIND_DEL, 64'sd0, 1'b1,
        '{sist_pkg::STAT_OK, 9'd3, 9'd8, sist_pkg::ENC_64}},
      '{sist_pkg::KIND_DEL, 64'sd0, 1'b1,
        '{sist_pkg::STAT_MISS, 9'd3, 9'd8, sist_pkg::ENC_64}},
      '{KIND_UNUSED, 64'sd1, 1'b1,
        '{sist_pkg::STAT_MISS, 9'd3, 9'd8, sist_pkg::ENC_64}},
      '{sist_pkg::KIND_DEL, INT64_MIN, 1'b1,
        '{sist_pkg::STAT_OK, 9'd0, 9'd7, sist_pkg::ENC_64}},
      '{sist_pkg::KIND_DEL, INT64_MAX, 1'b1,
        '{sist_pkg::STAT_OK, 9'd6, 9'd6, sist_pkg::ENC_64}},
      '{sist_pkg::KIND_ADD,    -64'sd1,                   1'b0, '0},
      '{sist_pkg::KIND_ADD,    64'sh5555_5555_5555_5555,  1'b0, '0},
      '{sist_pkg::KIND_ADD,    64'shAAAA_AAAA_AAAA_AAAA,  1'b0, '0},
      '{sist_pkg::KIND_SEARCH, 64'shAAAA_AAAA_AAAA_AAAA,  1'b0, '0},
      '{sist_pkg::KIND_DEL,    64'sd32767,                1'b0, '0},
      '{sist_pkg::KIND_SEARCH, -64'sd32769,               1'b0, '0}
    };

    none              = '0;
    set_count         = 0;
    set_class         = sist_pkg::ENC_16;
    long_hold         = 1'b0;
    mismatch_count    = 0;
    requests_sent     = 0;
    results_seen      = 0;
    full_refusals     = 0;
    peak_count        = 0;
    sender_idle_pct   = 17;
    receiver_idle_pct = 68;

    req_ch.valid = 1'b0;
    req_ch.kind  = sist_pkg::KIND_SEARCH;
    req_ch.value = '0;
    rst_n        = 1'b0;
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, sender light, receiver heavy
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.kind, row.value, row.fixed, row.result);
    end

    // Mixed traffic around a small, busy set
    for (int n = 0; n < N_MIXED; n++)
      send_request(random_kind(4, 3, 2), pick_value(), 1'b0, none);
    wait_all_results();

    // Swap idling and grow the set until it is full
    sender_idle_pct   = 68;
    receiver_idle_pct = 17;
    while (set_count < sist_pkg::CAPACITY) begin
      if ($urandom_range(0, 9) < 8)
        send_request(sist_pkg::KIND_ADD,
                     ($urandom_range(0, 4) != 0) ? longint'({$urandom, $urandom})
                                                 : pick_value(), 1'b0, none);
      else
        send_request(random_kind(0, 0, 3), pick_value(), 1'b0, none);
    end

    // Full table: adds are refused, or report a duplicate; searches still run.
    // Largest value gives the insertion point just past the last slot, unless it is stored.
    send_request(sist_pkg::KIND_ADD, INT64_MAX, 1'b0, none);
    for (int n = 0; n < N_AT_FULL; n++)
      send_request(random_kind(6, 0, 3), pick_value(), 1'b0, none);
    wait_all_results();

    // No idling; receiver first holds off long enough for the block to
    // back up and stall its input, then deletes thin the set out
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    long_hold         = 1'b1;
    for (int n = 0; n < N_DRAIN; n++)
      send_request(random_kind(2, 5, 2), pick_value(), 1'b0, none);
    wait_all_results();
    repeat (24) @(posedge clk);

    $display("tb: %0d requests, %0d results checked, %0d mismatches", requests_sent,
             results_seen, mismatch_count);
    $display("tb: set peaked at %0d entries, %0d adds refused as full, final class %0d",
             peak_count, full_refusals, set_class);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
